>>> hdl/bsc_pkg.sv
// shared types and constants of the barometric sensor compensation block
package bsc_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_TEMP_CALIB  = 2'd0;
  localparam logic [1:0] CFG_PRESS_LOW   = 2'd1;
  localparam logic [1:0] CFG_PRESS_HIGH  = 2'd2;
  localparam logic [1:0] CFG_PRESS_LAST  = 2'd3;

  localparam int DIV_W = 64;

  // temperature results carried beside the pressure path
  typedef struct packed {
    logic [31:0] fine;
    logic [31:0] centi;
  } tc_t;

  // temperature stage output
  typedef struct packed {
    tc_t         tc;
    logic [19:0] raw_p;
  } tp_t;

  // divider request: signed numerator and divisor
  typedef struct packed {
    logic [63:0] num;
    logic [63:0] den;
    tc_t         tc;
  } div_req_t;

  // one step of the divider
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] nq;
    logic [63:0] md;
    logic        neg;
    logic        ok;
    tc_t         tc;
  } div_st_t;

  // signed quotient handed to the final scaling
  typedef struct packed {
    logic [63:0] p;
    logic        ok;
    tc_t         tc;
  } quo_t;

  // finished result
  typedef struct packed {
    tc_t         tc;
    logic [31:0] press;
    logic        ok;
  } res_t;

endpackage

>>> hdl/bsc_temp.sv
// temperature compensation pipeline, five stages
module bsc_temp (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [19:0]       raw_t,
  input  logic [19:0]       raw_p,
  input  logic [47:0]       temp_calib,
  output logic              out_valid,
  output bsc_pkg::tp_t      out_data
);

  logic [15:0] t1;
  logic signed [15:0] t2, t3;
  assign t1 = temp_calib[15:0];
  assign t2 = temp_calib[31:16];
  assign t3 = temp_calib[47:32];

  logic v1, v2, v3, v4, v5;
  logic [31:0] a1, b1;
  logic [19:0] rp1, rp2, rp3, rp4, rp5;
  logic [31:0] v1t2, bb2, v1t3, v2t3, fine4;
  logic signed [47:0] pa, pc;
  logic [63:0] pb;
  logic [31:0] f5, c5;

  assign pa = $signed(a1) * t2;
  assign pb = b1 * b1;
  assign pc = ($signed(bb2) >>> 12) * t3;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      a1   <= {15'd0, raw_t[19:3]} - {15'd0, t1, 1'b0};
      b1   <= {16'd0, raw_t[19:4]} - {16'd0, t1};
      rp1  <= raw_p;
      v1t2 <= 32'($signed(pa[31:0]) >>> 11);
      bb2  <= pb[31:0];
      rp2  <= rp1;
      v1t3 <= v1t2;
      v2t3 <= 32'($signed(pc[31:0]) >>> 14);
      rp3  <= rp2;
      fine4 <= v1t3 + v2t3;
      rp4  <= rp3;
      f5   <= fine4;
      c5   <= 32'($signed({fine4[29:0], 2'b00} + fine4 + 32'd128) >>> 8);
      rp5  <= rp4;
    end
  end

  assign out_valid = v5;
  assign out_data  = {f5, c5, rp5};

endmodule

>>> hdl/bsc_press.sv
// pressure numerator and divisor pipeline, nine stages
module bsc_press (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  bsc_pkg::tp_t       in_data,
  input  logic [63:0]        press_low,
  input  logic [63:0]        press_high,
  output logic               out_valid,
  output bsc_pkg::div_req_t  out_data
);

  logic [15:0] p1;
  logic signed [15:0] p2, p3, p4, p5, p6;
  assign p1 = press_low[15:0];
  assign p2 = press_low[31:16];
  assign p3 = press_low[47:32];
  assign p4 = press_low[63:48];
  assign p5 = press_high[15:0];
  assign p6 = press_high[31:16];

  logic vld [0:8];
  bsc_pkg::tc_t tc [0:7];
  bsc_pkg::tc_t tc8;
  logic [20:0] pp [0:4];

  logic [63:0] v1_0, sq1, v2a3, s3_3, v2_4, v1b_4, x5, n05, m1_7, num7, num8, den8;
  logic [31:0] am;
  logic [49:0] v1p5_1, v1p2_1, v1p5_2, v1p2_2, v1p5_3, v1p2_3;
  logic signed [49:0] v1p5c, v1p2c;
  logic signed [48:0] l6, l3;
  logic [31:0] h6, h3, hx, hn;
  logic [47:0] lx;
  logic [43:0] ln;
  logic signed [48:0] l6c, l3c;
  logic [63:0] h6f, h3f, hxf, hnf;
  logic [47:0] lxc;
  logic [43:0] lnc;
  logic [63:0] m1v;

  // linear terms by p5 and p2
  assign v1p5c = $signed(v1_0[33:0]) * p5;
  assign v1p2c = $signed(v1_0[33:0]) * p2;

  // multiply partials by p6, p3, p1 and 3125
  assign am  = v1_0[63] ? 32'(64'd0 - v1_0) : v1_0[31:0];
  assign l6c = $signed({1'b0, sq1[31:0]}) * p6;
  assign l3c = $signed({1'b0, sq1[31:0]}) * p3;
  assign h6f = sq1[63:32] * {{16{p6[15]}}, p6};
  assign h3f = sq1[63:32] * {{16{p3[15]}}, p3};
  assign lxc = x5[31:0] * p1;
  assign hxf = x5[63:32] * {16'd0, p1};
  assign lnc = n05[31:0] * 12'd3125;
  assign hnf = n05[63:32] * 32'd3125;
  assign m1v = {hx, 32'd0} + {16'd0, lx};

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i < 9; i++) vld[i] <= vld[i-1];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      tc[0] <= in_data.tc;
      for (int i = 1; i < 8; i++) tc[i] <= tc[i-1];
      pp[0] <= 21'd1048576 - {1'b0, in_data.raw_p};
      for (int i = 1; i < 5; i++) pp[i] <= pp[i-1];
      // offset fine temperature
      v1_0 <= {{32{in_data.tc.fine[31]}}, in_data.tc.fine} - 64'd128000;
      // square and linear terms
      sq1    <= am * am;
      v1p5_1 <= v1p5c;
      v1p2_1 <= v1p2c;
      // wide products by p6 and p3, partials
      l6 <= l6c; h6 <= h6f[31:0];
      l3 <= l3c; h3 <= h3f[31:0];
      v1p5_2 <= v1p5_1; v1p2_2 <= v1p2_1;
      // wide products, combine
      v2a3 <= {h6, 32'd0} + {{15{l6[48]}}, l6};
      s3_3 <= {h3, 32'd0} + {{15{l3[48]}}, l3};
      v1p5_3 <= v1p5_2; v1p2_3 <= v1p2_2;
      // var2 and var1 sums
      v2_4  <= v2a3 + ({{14{v1p5_3[49]}}, v1p5_3} << 17) + ({{48{p4[15]}}, p4} << 35);
      v1b_4 <= 64'($signed(s3_3) >>> 8) + ({{14{v1p2_3[49]}}, v1p2_3} << 12);
      // offset var1, numerator before scaling
      x5  <= 64'h0000_8000_0000_0000 + v1b_4;
      n05 <= ({43'd0, pp[4]} << 31) - v2_4;
      // partials by p1 and by 3125
      lx <= lxc; hx <= hxf[31:0];
      ln <= lnc; hn <= hnf[31:0];
      // combine
      m1_7 <= m1v;
      num7 <= {hn, 32'd0} + {20'd0, ln};
      // divisor
      num8 <= num7;
      den8 <= 64'($signed(m1_7) >>> 33);
      tc8  <= tc[7];
    end
  end

  assign out_valid = vld[8];
  assign out_data  = {num8, den8, tc8};

endmodule

>>> hdl/bsc_div.sv
// pipelined signed 64-bit division, one quotient bit per stage
module bsc_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  bsc_pkg::div_req_t  in_data,
  output logic               out_valid,
  output bsc_pkg::quo_t      out_data
);

  localparam int N = bsc_pkg::DIV_W;

  bsc_pkg::div_st_t st [0:N];
  logic dv [0:N];
  logic ov;
  bsc_pkg::quo_t oq;

  // magnitudes and signs
  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (adv) dv[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0].rem <= '0;
      st[0].nq  <= in_data.num[63] ? 64'd0 - in_data.num : in_data.num;
      st[0].md  <= in_data.den[63] ? 64'd0 - in_data.den : in_data.den;
      st[0].neg <= in_data.num[63] ^ in_data.den[63];
      st[0].ok  <= (in_data.den != 64'd0);
      st[0].tc  <= in_data.tc;
    end
  end

  // restoring steps
  for (genvar k = 0; k < N; k++) begin : g_step
    logic [64:0] rs;
    logic [64:0] df;
    logic ge;
    assign rs = {st[k].rem, st[k].nq[63]};
    assign df = rs - {1'b0, st[k].md};
    assign ge = (rs >= {1'b0, st[k].md});

    always_ff @(posedge clk) begin
      if (rst) dv[k+1] <= 1'b0;
      else if (adv) dv[k+1] <= dv[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[k+1].rem <= ge ? df[63:0] : rs[63:0];
        st[k+1].nq  <= {st[k].nq[62:0], ge};
        st[k+1].md  <= st[k].md;
        st[k+1].neg <= st[k].neg;
        st[k+1].ok  <= st[k].ok;
        st[k+1].tc  <= st[k].tc;
      end
    end
  end

  // sign of the quotient
  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (adv) ov <= dv[N];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oq.p  <= st[N].neg ? 64'd0 - st[N].nq : st[N].nq;
      oq.ok <= st[N].ok;
      oq.tc <= st[N].tc;
    end
  end

  assign out_valid = ov;
  assign out_data  = oq;

endmodule

>>> hdl/bsc_post.sv
// final pressure scaling, six stages, last one is the output register
module bsc_post (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_valid,
  input  bsc_pkg::quo_t  in_data,
  input  logic [63:0]    press_high,
  input  logic [15:0]    press_last,
  output logic           out_valid,
  output bsc_pkg::res_t  out_data
);

  logic signed [15:0] p7, p8, p9;
  assign p7 = press_high[47:32];
  assign p8 = press_high[63:48];
  assign p9 = press_last;

  logic vld [0:5];
  bsc_pkg::tc_t tc [0:4];
  logic ok [0:4];
  logic [63:0] p [0:4];

  logic [63:0] q13, llc, lhc, h8f, h9f;
  logic signed [48:0] l8c, l9c;
  logic [63:0] ll1, qq2, m8_2, m8_3, m8_4, m9_4, sum5;
  logic [31:0] lh1, h8, h9;
  logic signed [48:0] l8, l9;
  logic [63:0] res;

  // square of p >> 13 and product by p8, partials
  assign q13 = 64'($signed(in_data.p) >>> 13);
  assign llc = q13[31:0] * q13[31:0];
  assign lhc = q13[31:0] * q13[63:32];
  assign l8c = $signed({1'b0, in_data.p[31:0]}) * p8;
  assign h8f = in_data.p[63:32] * {{16{p8[15]}}, p8};
  // product of the square by p9, partials
  assign l9c = $signed({1'b0, qq2[31:0]}) * p9;
  assign h9f = qq2[63:32] * {{16{p9[15]}}, p9};
  assign res = 64'($signed(sum5) >>> 8) + ({{48{p7[15]}}, p7} << 4);

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i < 6; i++) vld[i] <= vld[i-1];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      tc[0] <= in_data.tc; ok[0] <= in_data.ok; p[0] <= in_data.p;
      for (int i = 1; i < 5; i++) begin
        tc[i] <= tc[i-1]; ok[i] <= ok[i-1]; p[i] <= p[i-1];
      end
      ll1 <= llc; lh1 <= lhc[31:0];
      l8  <= l8c; h8  <= h8f[31:0];
      // combine
      qq2  <= ll1 + {lh1[30:0], 1'b0, 32'd0};
      m8_2 <= {h8, 32'd0} + {{15{l8[48]}}, l8};
      l9   <= l9c; h9 <= h9f[31:0];
      m8_3 <= m8_2;
      m9_4 <= {h9, 32'd0} + {{15{l9[48]}}, l9};
      m8_4 <= m8_3;
      // sum of the three terms
      sum5 <= p[3] + 64'($signed(m9_4) >>> 25) + 64'($signed(m8_4) >>> 19);
      // final offset and output register
      out_data.tc    <= tc[4];
      out_data.ok    <= ok[4];
      out_data.press <= ok[4] ? res[31:0] : 32'd0;
    end
  end

  assign out_valid = vld[5];

endmodule

>>> hdl/baro_sensor_compensation_top.sv
// top level of the barometric sensor compensation block
//
//  port group   dir  contents
//  s_t*         in   raw readings request, tdata: raw_temperature, raw_pressure
//  m_t*         out  compensated result, tdata: fine, centi, pressure; tuser: valid
//  cfg_*        in   calibration register writes, index 0..3
//
// one request accepted per cycle unless the output stalls; request and result are parted by the 64
// quotient steps of the restoring divider plus 22 stages of multiply, add and sign handling.
// reset clears the valid bits and the calibration registers; no request is taken in reset.
// a stall at the output freezes the whole pipeline; nothing is lost.
module baro_sensor_compensation_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // fine_temperature, temperature_centi, pressure_q24_8
  output logic [0:0]  m_tuser,   // pressure_valid
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [47:0] temp_calib;
  logic [63:0] press_low, press_high;
  logic [15:0] press_last;
  logic adv;

  logic t_vld, p_vld, d_vld, o_vld;
  bsc_pkg::tp_t      t_out;
  bsc_pkg::div_req_t p_out;
  bsc_pkg::quo_t     d_out;
  bsc_pkg::res_t     o_out;

  // calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib <= '0;
      press_low  <= '0;
      press_high <= '0;
      press_last <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bsc_pkg::CFG_TEMP_CALIB: temp_calib <= cfg_data[47:0];
        bsc_pkg::CFG_PRESS_LOW:  press_low  <= cfg_data;
        bsc_pkg::CFG_PRESS_HIGH: press_high <= cfg_data;
        bsc_pkg::CFG_PRESS_LAST: press_last <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // pipeline advances unless the result waits
  assign adv      = !o_vld || m_tready;
  assign s_tready = adv && !rst;

  bsc_temp u_temp (
    .clk, .rst, .adv,
    .in_valid   (s_tvalid),
    .raw_t      (s_tdata[19:0]),
    .raw_p      (s_tdata[39:20]),
    .temp_calib (temp_calib),
    .out_valid  (t_vld),
    .out_data   (t_out)
  );

  bsc_press u_press (
    .clk, .rst, .adv,
    .in_valid   (t_vld),
    .in_data    (t_out),
    .press_low  (press_low),
    .press_high (press_high),
    .out_valid  (p_vld),
    .out_data   (p_out)
  );

  bsc_div u_div (
    .clk, .rst, .adv,
    .in_valid  (p_vld),
    .in_data   (p_out),
    .out_valid (d_vld),
    .out_data  (d_out)
  );

  bsc_post u_post (
    .clk, .rst, .adv,
    .in_valid   (d_vld),
    .in_data    (d_out),
    .press_high (press_high),
    .press_last (press_last),
    .out_valid  (o_vld),
    .out_data   (o_out)
  );

  assign m_tvalid = o_vld;
  assign m_tdata  = {o_out.press, o_out.tc.centi, o_out.tc.fine};
  assign m_tuser  = o_out.ok;

endmodule
